### rtl/rft_pkg.sv
// Shared types, constants and register codes of the rail fence transposition block.
`default_nettype none

package rft_pkg;

    localparam int MAX_LEN_DEF   = 64;
    localparam int MAX_RAILS_DEF = 16;

    localparam int RAIL_W    = 5;
    localparam int RAIL_RST  = 3;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    typedef enum logic {
        REG_RAIL_COUNT   = 1'b0,
        REG_DECRYPT_MODE = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_LOAD,
        S_ENC_RD,
        S_ENC_OUT,
        S_DEC_RD,
        S_DEC_WR,
        S_DEC2_RD,
        S_DEC2_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic adv;
    } t_walk_cmd;

endpackage

`default_nettype wire

### rtl/rft_if.sv
// Valid/ready channel interfaces for the input bytes and the transposed output bytes.
`default_nettype none

interface rft_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last_in;

    modport source (output valid, output char_in, output last_in, input ready);
    modport sink   (input valid, input char_in, input last_in, output ready);
endinterface

interface rft_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last_out;
    logic       truncated;

    modport source (output valid, output char_out, output last_out, output truncated,
                    input ready);
    modport sink   (input valid, input char_out, input last_out, input truncated,
                    output ready);
endinterface

`default_nettype wire

### rtl/rail_fence_transposition.sv
// Top level of the rail fence transposition block: sequencer, message buffers and ports.
`default_nettype none

// The block takes one message byte per cycle into its buffer while i_in.ready is high. The
// transaction that carries last_in starts the output of the whole message, during which no
// input is accepted. In encrypt mode each output byte passes a buffer read state, then an
// output state. The position generator moves on to the next rail once the current one is
// used up, which can overlap an output state; a rail that starts past the message end holds
// back the read state. Decrypt mode first scatters the buffer into a result memory (read,
// then write per byte), then streams it out (read, then output per byte). The sink may stall
// any output state. The position generator has one shared adder, each memory one read port.
module rail_fence_transposition #(
    parameter int MAX_LEN   = rft_pkg::MAX_LEN_DEF,
    parameter int MAX_RAILS = rft_pkg::MAX_RAILS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    rft_in_if.sink                          i_in,
    rft_out_if.source                       o_out,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rft_pkg::APB_AW-1:0] paddr,
    input  wire logic [rft_pkg::APB_DW-1:0] pwdata,
    output logic      [rft_pkg::APB_DW-1:0] prdata,
    output logic                            pready
);
    import rft_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);

    logic [RAIL_W-1:0] rail_count;
    logic              decrypt_mode;
    logic [RAIL_W-1:0] rails_eff;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_ovf, n_ovf;
    logic [AW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_wpos, n_wpos;

    t_walk_cmd         walk_cmd;
    logic              walk_ok;
    logic [AW-1:0]     walk_pos;

    logic [7:0]        buf_mem [MAX_LEN];
    logic [7:0]        res_mem [MAX_LEN];
    logic [7:0]        r_buf_q;
    logic [7:0]        r_res_q;
    logic              buf_we, buf_re, res_we, res_re;
    logic [AW-1:0]     buf_ra;

    logic              in_acc, out_acc, idx_last;

    rft_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_rail_count   (rail_count),
        .o_decrypt_mode (decrypt_mode)
    );

    always_comb begin
        if (rail_count == '0) begin
            rails_eff = RAIL_W'(1);
        end else if (32'(rail_count) > MAX_RAILS) begin
            rails_eff = RAIL_W'(MAX_RAILS);
        end else begin
            rails_eff = rail_count;
        end
    end

    rft_walk #(
        .MAX_LEN (MAX_LEN)
    ) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (walk_cmd),
        .i_n     (r_count),
        .i_rails (rails_eff),
        .o_ok    (walk_ok),
        .o_pos   (walk_pos)
    );

    assign in_acc   = i_in.valid & i_in.ready;
    assign out_acc  = o_out.valid & o_out.ready;
    assign idx_last = (CW'(r_idx) == r_count - CW'(1));

    assign i_in.ready      = (r_state == S_LOAD);
    assign o_out.valid     = (r_state == S_ENC_OUT) || (r_state == S_DEC2_OUT);
    assign o_out.char_out  = (r_state == S_DEC2_OUT) ? r_res_q : r_buf_q;
    assign o_out.last_out  = idx_last;
    assign o_out.truncated = r_ovf;

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_ovf          = r_ovf;
        n_idx          = r_idx;
        n_wpos         = r_wpos;
        walk_cmd.start = 1'b0;
        walk_cmd.adv   = 1'b0;
        buf_we         = 1'b0;
        buf_re         = 1'b0;
        buf_ra         = walk_pos;
        res_we         = 1'b0;
        res_re         = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (r_count < CW'(MAX_LEN)) begin
                        buf_we  = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last_in) begin
                        walk_cmd.start = 1'b1;
                        n_idx          = '0;
                        n_state        = decrypt_mode ? S_DEC_RD : S_ENC_RD;
                    end
                end
            end
            S_ENC_RD: begin
                if (walk_ok) begin
                    buf_re       = 1'b1;
                    walk_cmd.adv = 1'b1;
                    n_state      = S_ENC_OUT;
                end
            end
            S_ENC_OUT: begin
                if (out_acc) begin
                    if (idx_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_ENC_RD;
                    end
                end
            end
            S_DEC_RD: begin
                if (walk_ok) begin
                    buf_re       = 1'b1;
                    buf_ra       = r_idx;
                    n_wpos       = walk_pos;
                    walk_cmd.adv = 1'b1;
                    n_state      = S_DEC_WR;
                end
            end
            S_DEC_WR: begin
                res_we = 1'b1;
                if (idx_last) begin
                    n_idx   = '0;
                    n_state = S_DEC2_RD;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_DEC_RD;
                end
            end
            S_DEC2_RD: begin
                res_re  = 1'b1;
                n_state = S_DEC2_OUT;
            end
            S_DEC2_OUT: begin
                if (out_acc) begin
                    if (idx_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_DEC2_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wpos <= n_wpos;
    end

    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            buf_mem[r_count[AW-1:0]] <= i_in.char_in;
        end
        if (buf_re) begin
            r_buf_q <= buf_mem[buf_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_we) begin
            res_mem[r_wpos] <= r_buf_q;
        end
        if (res_re) begin
            r_res_q <= res_mem[r_idx];
        end
    end

endmodule

`default_nettype wire

### rtl/rft_cfg.sv
// APB-style configuration registers for rail count and decrypt mode.
`default_nettype none

module rft_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rft_pkg::APB_AW-1:0] paddr,
    input  wire logic [rft_pkg::APB_DW-1:0] pwdata,
    output logic      [rft_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output logic      [rft_pkg::RAIL_W-1:0] o_rail_count,
    output logic                            o_decrypt_mode
);
    import rft_pkg::*;

    logic [RAIL_W-1:0] r_rail_count;
    logic              r_decrypt_mode;
    logic              wr_en;
    t_reg_idx          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rail_count   <= RAIL_W'(RAIL_RST);
            r_decrypt_mode <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_RAIL_COUNT:   r_rail_count   <= pwdata[RAIL_W-1:0];
                REG_DECRYPT_MODE: r_decrypt_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RAIL_COUNT:   prdata = APB_DW'(r_rail_count);
            REG_DECRYPT_MODE: prdata = APB_DW'(r_decrypt_mode);
            default:          prdata = '0;
        endcase
    end

    assign o_rail_count   = r_rail_count;
    assign o_decrypt_mode = r_decrypt_mode;

endmodule

`default_nettype wire

### rtl/rft_walk.sv
// Zigzag position generator that lists message positions rail by rail with one shared adder.
`default_nettype none

module rft_walk #(
    parameter int MAX_LEN = rft_pkg::MAX_LEN_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire rft_pkg::t_walk_cmd                 i_cmd,
    input  wire logic [$clog2(MAX_LEN+1)-1:0]       i_n,
    input  wire logic [rft_pkg::RAIL_W-1:0]         i_rails,
    output logic                                    o_ok,
    output logic      [$clog2(MAX_LEN)-1:0]         o_pos
);
    import rft_pkg::*;

    localparam int CW    = $clog2(MAX_LEN + 1);
    localparam int AW    = $clog2(MAX_LEN);
    localparam int DW    = RAIL_W + 1;
    localparam int SUM_W = ((CW > DW) ? CW : DW) + 1;

    logic              r_busy, n_busy;
    logic [RAIL_W-1:0] r_rail, n_rail;
    logic [SUM_W-1:0]  r_pos, n_pos;
    logic              r_phase, n_phase;
    logic [DW-1:0]     r_d1, n_d1;
    logic [DW-1:0]     r_d2, n_d2;

    logic              last_rail;
    logic [DW-1:0]     step;
    logic [SUM_W-1:0]  add_a, add_b, sum;

    assign o_ok      = r_busy && (r_pos < SUM_W'(i_n));
    assign o_pos     = r_pos[AW-1:0];
    assign last_rail = (r_rail == i_rails - RAIL_W'(1));

    always_comb begin
        if (i_rails == RAIL_W'(1)) begin
            step = DW'(1);
        end else if (r_d1 == '0) begin
            step = r_d2;
        end else if (r_d2 == '0) begin
            step = r_d1;
        end else begin
            step = r_phase ? r_d2 : r_d1;
        end
    end

    always_comb begin
        if (i_cmd.adv) begin
            add_a = r_pos;
            add_b = SUM_W'(step);
        end else begin
            add_a = SUM_W'(r_rail);
            add_b = SUM_W'(1);
        end
        sum = add_a + add_b;
    end

    always_comb begin
        n_busy  = r_busy;
        n_rail  = r_rail;
        n_pos   = r_pos;
        n_phase = r_phase;
        n_d1    = r_d1;
        n_d2    = r_d2;
        if (i_cmd.start) begin
            n_busy  = 1'b1;
            n_rail  = '0;
            n_pos   = '0;
            n_phase = 1'b0;
            n_d1    = {i_rails - RAIL_W'(1), 1'b0};
            n_d2    = '0;
        end else if (i_cmd.adv) begin
            n_pos   = sum;
            n_phase = ~r_phase;
        end else if (r_busy && !o_ok && !last_rail) begin
            n_rail  = sum[RAIL_W-1:0];
            n_pos   = sum;
            n_phase = 1'b0;
            n_d1    = r_d1 - DW'(2);
            n_d2    = r_d2 + DW'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_rail  <= '0;
            r_pos   <= '0;
            r_phase <= 1'b0;
            r_d1    <= '0;
            r_d2    <= '0;
        end else begin
            r_busy  <= n_busy;
            r_rail  <= n_rail;
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_d1    <= n_d1;
            r_d2    <= n_d2;
        end
    end

endmodule

`default_nettype wire
